// ===== rtl/ordered_list_table_assert.svh =====
// ----------------------------------------------------------------------------
// ordered_list_table assertion macros
// Immediate-implication and next-cycle-implication checks on the block clock.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define OLT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OLT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/olt_pkg.sv =====
// ----------------------------------------------------------------------------
// olt_pkg
// Operation codes shared by the ordered list table.
// ----------------------------------------------------------------------------
package olt_pkg;

   typedef logic [2:0] opcode_type;

   localparam opcode_type OP_APPEND = 3'd0;
   localparam opcode_type OP_INSERT = 3'd1;
   localparam opcode_type OP_SEARCH = 3'd2;
   localparam opcode_type OP_DELETE = 3'd3;
   localparam opcode_type OP_QUERY  = 3'd4;

endpackage

// ===== rtl/olt_ram.sv =====
// ----------------------------------------------------------------------------
// olt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ordered_list_table.sv =====
// ----------------------------------------------------------------------------
// ordered_list_table
// Bounded ordered list of 64-bit words kept as linked nodes in two RAMs.
// ----------------------------------------------------------------------------
// One command at a time: a command is taken when start is high and busy is
// low, and exactly one result follows on rsp_strobe for a single cycle; the
// receiver cannot stall it. A query, or an append/insert that overflows, or a
// search/delete on an empty list, gives its result the cycle after it is
// taken. An append, or an insert at the head or at/past the end, passes
// ST_ALLOC only. An insert at position p inside the list passes ST_ALLOC,
// ST_INS_WALK and ST_INS_LINK. A search or delete walks in ST_FIND; a
// delete of a node other than the sole entry then passes ST_DEL_FRONT or
// ST_DEL_FREE. Walks are set by the node RAMs: one node is read per cycle
// through their single registered read port, so the worst case is a delete
// of the last node of a full list. busy is low in the cycle the result is
// shown, so the next command may be taken there. Freed nodes are chained
// through the link RAM; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ordered_list_table #(
   parameter int CAPACITY = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  olt_pkg::opcode_type req_operation,
   input  logic [7:0]          req_position,
   input  logic [63:0]         req_value,
   output logic                rsp_strobe,
   output logic                rsp_found,
   output logic                rsp_is_empty,
   output logic [63:0]         rsp_front_value,
   output logic [5:0]          rsp_length,
   output logic                rsp_overflow
);

   import olt_pkg::*;

   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > 8) ? CW : 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_INS_WALK,
      ST_INS_LINK,
      ST_FIND,
      ST_DEL_FRONT,
      ST_DEL_FREE
   } state_type;

   state_type        state_ff;
   logic [SW-1:0]    head_ff;
   logic [SW-1:0]    tail_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    used_ff;
   logic [SW-1:0]    free_head_ff;
   logic [63:0]      front_ff;
   logic             rsp_strobe_ff;
   logic             found_ff;
   logic             overflow_ff;
   opcode_type       op_ff;
   logic [7:0]       pos_ff;
   logic [63:0]      val_ff;
   logic [SW-1:0]    slot_ff;
   logic             use_free_ff;
   logic [SW-1:0]    cur_ff;
   logic [SW-1:0]    prev_ff;
   logic [CW-1:0]    idx_ff;

   logic [SW-1:0]    rd_addr;
   logic [63:0]      val_rdata;
   logic [SW-1:0]    link_rdata;
   logic             val_wr_en;
   logic             link_wr_en;
   logic [SW-1:0]    link_wr_addr;
   logic [SW-1:0]    link_wr_data;

   logic             req_add;
   logic             req_walk;
   logic             add_at_tail;
   logic             value_hit;
   logic             walk_last;
   logic             ins_reached;
   logic [CW-1:0]    count_dec;

   // command decode and walk conditions
   assign req_add     = (req_operation == OP_APPEND) || (req_operation == OP_INSERT);
   assign req_walk    = (req_operation == OP_SEARCH) || (req_operation == OP_DELETE);
   assign add_at_tail = (op_ff == OP_APPEND) || (count_ff == '0)
                        || (IW'(pos_ff) >= IW'(count_ff));
   assign value_hit   = (val_rdata == val_ff);
   assign count_dec   = count_ff - CW'(1);
   assign walk_last   = (idx_ff == count_dec);
   assign ins_reached = (IW'(idx_ff) == IW'(pos_ff));

   // node RAM read address and write ports
   always_comb begin
      rd_addr      = head_ff;
      val_wr_en    = 1'b0;
      link_wr_en   = 1'b0;
      link_wr_addr = cur_ff;
      link_wr_data = free_head_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = (start && req_add) ? free_head_ff : head_ff;
         end
         ST_ALLOC: begin
            rd_addr   = head_ff;
            val_wr_en = 1'b1;
            if (add_at_tail) begin
               link_wr_en   = (count_ff != '0);
               link_wr_addr = tail_ff;
               link_wr_data = slot_ff;
            end else if (pos_ff == '0) begin
               link_wr_en   = 1'b1;
               link_wr_addr = slot_ff;
               link_wr_data = head_ff;
            end
         end
         ST_INS_WALK: begin
            rd_addr = link_rdata;
            if (ins_reached) begin
               link_wr_en   = 1'b1;
               link_wr_addr = slot_ff;
               link_wr_data = link_rdata;
            end
         end
         ST_INS_LINK: begin
            link_wr_en   = 1'b1;
            link_wr_addr = cur_ff;
            link_wr_data = slot_ff;
         end
         ST_FIND: begin
            rd_addr = link_rdata;
            if (value_hit && (op_ff == OP_DELETE)) begin
               link_wr_en = 1'b1;
               if (idx_ff == '0) begin
                  link_wr_addr = cur_ff;
                  link_wr_data = free_head_ff;
               end else begin
                  link_wr_addr = prev_ff;
                  link_wr_data = link_rdata;
               end
            end
         end
         ST_DEL_FREE: begin
            link_wr_en   = 1'b1;
            link_wr_addr = cur_ff;
            link_wr_data = free_head_ff;
         end
         default: begin
            rd_addr = head_ff;
         end
      endcase
   end

   // node values
   olt_ram #(
      .WIDTH (64),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (slot_ff),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (val_rdata)
   );

   // next links, also chaining the free nodes
   olt_ram #(
      .WIDTH (SW),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   // command sequencer, list pointers and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         used_ff       <= '0;
         free_head_ff  <= '0;
         front_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         found_ff      <= 1'b0;
         overflow_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff       <= req_operation;
                  pos_ff      <= req_position;
                  val_ff      <= req_value;
                  found_ff    <= 1'b0;
                  overflow_ff <= 1'b0;
                  cur_ff      <= head_ff;
                  prev_ff     <= head_ff;
                  idx_ff      <= '0;
                  if (req_add) begin
                     if (count_ff == CW'(CAPACITY)) begin
                        overflow_ff   <= 1'b1;
                        rsp_strobe_ff <= 1'b1;
                     end else begin
                        // reuse a freed node if any, else a never-used one
                        use_free_ff <= (used_ff != count_ff);
                        if (used_ff != count_ff) begin
                           slot_ff <= free_head_ff;
                        end else begin
                           slot_ff <= used_ff[SW-1:0];
                           used_ff <= used_ff + CW'(1);
                        end
                        state_ff <= ST_ALLOC;
                     end
                  end else if (req_walk && (count_ff != '0)) begin
                     state_ff <= ST_FIND;
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                  end
               end
            end
            ST_ALLOC: begin
               if (use_free_ff) begin
                  free_head_ff <= link_rdata;
               end
               count_ff <= count_ff + CW'(1);
               if (add_at_tail) begin
                  if (count_ff == '0) begin
                     head_ff  <= slot_ff;
                     front_ff <= val_ff;
                  end
                  tail_ff       <= slot_ff;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else if (pos_ff == '0) begin
                  head_ff       <= slot_ff;
                  front_ff      <= val_ff;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  cur_ff   <= head_ff;
                  idx_ff   <= CW'(1);
                  state_ff <= ST_INS_WALK;
               end
            end
            ST_INS_WALK: begin
               if (ins_reached) begin
                  state_ff <= ST_INS_LINK;
               end else begin
                  cur_ff <= link_rdata;
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            ST_INS_LINK: begin
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            ST_FIND: begin
               if (value_hit) begin
                  found_ff <= 1'b1;
                  if (op_ff == OP_DELETE) begin
                     count_ff <= count_dec;
                     if (idx_ff == '0) begin
                        // unlink the head and push it on the free chain
                        free_head_ff <= cur_ff;
                        if (count_ff == CW'(1)) begin
                           head_ff       <= '0;
                           tail_ff       <= '0;
                           front_ff      <= '0;
                           rsp_strobe_ff <= 1'b1;
                           state_ff      <= ST_IDLE;
                        end else begin
                           head_ff  <= link_rdata;
                           state_ff <= ST_DEL_FRONT;
                        end
                     end else begin
                        if (walk_last) begin
                           tail_ff <= prev_ff;
                        end
                        state_ff <= ST_DEL_FREE;
                     end
                  end else begin
                     rsp_strobe_ff <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end
               end else if (walk_last) begin
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end else begin
                  prev_ff <= cur_ff;
                  cur_ff  <= link_rdata;
                  idx_ff  <= idx_ff + CW'(1);
               end
            end
            ST_DEL_FRONT: begin
               front_ff      <= val_rdata;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            ST_DEL_FREE: begin
               free_head_ff  <= cur_ff;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // result ports
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = found_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_is_empty    = (count_ff == '0);
   assign rsp_front_value = front_ff;
   assign rsp_length      = 6'(count_ff);

   // checks
   `include "ordered_list_table_assert.svh"

   `OLT_ASSERT_NEXT(a_transfer_progress, start && !busy, busy || rsp_strobe, "taken command stalled")
   `OLT_ASSERT_NOW(a_free_accounting, 1'b1, (used_ff >= count_ff) && (count_ff <= CW'(CAPACITY)), "node accounting broken")
   `OLT_ASSERT_NOW(a_overflow_full, rsp_strobe && rsp_overflow, count_ff == CW'(CAPACITY), "overflow while not full")
   `OLT_ASSERT_NOW(a_empty_front, count_ff == '0, front_ff == '0, "front value not cleared when empty")

endmodule
